### rtl/sbif_pkg.sv
// shared types and constants of the servo-bus instruction framer
`default_nettype none
package sbif_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CNT_W  = 7;

  localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hFF;
  localparam logic [BYTE_W-1:0] LEN_EXTRA = 8'd2;

  // per-item byte plan, worked out at the input transfer
  typedef struct packed {
    logic              first;      // item opens a packet: header goes out first
    logic              has_param;  // item carries a parameter byte
    logic              has_chk;    // item closes the packet with the checksum
    logic [BYTE_W-1:0] id;
    logic [BYTE_W-1:0] len;
    logic [BYTE_W-1:0] ins;
    logic [BYTE_W-1:0] param;
    logic [BYTE_W-1:0] chk;
  } plan_t;

  // output byte slot of the item being sent
  typedef enum logic [7:0] {
    SLOT_IDLE  = 8'b0000_0001,
    SLOT_SYNC0 = 8'b0000_0010,
    SLOT_SYNC1 = 8'b0000_0100,
    SLOT_ID    = 8'b0000_1000,
    SLOT_LEN   = 8'b0001_0000,
    SLOT_INS   = 8'b0010_0000,
    SLOT_PARAM = 8'b0100_0000,
    SLOT_CHK   = 8'b1000_0000
  } slot_t;

endpackage
`default_nettype wire

### rtl/sbif_tracker.sv
// packet state tracker: saturation, length, running sum and per-item byte plan
`default_nettype none
module sbif_tracker #(
  parameter int unsigned MAX_PARAMS = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           accept,
  input  wire logic [sbif_pkg::BYTE_W-1:0]    target_id,
  input  wire logic [sbif_pkg::BYTE_W-1:0]    instruction,
  input  wire logic [sbif_pkg::CNT_W-1:0]     param_count,
  input  wire logic [sbif_pkg::BYTE_W-1:0]    param_byte,
  output sbif_pkg::plan_t                     plan
);

  localparam logic [sbif_pkg::CNT_W:0] MaxP = (sbif_pkg::CNT_W + 1)'(MAX_PARAMS);

  logic                          in_packet_r, in_packet_nxt;
  logic [sbif_pkg::CNT_W-1:0]    left_r, left_nxt;
  logic [sbif_pkg::BYTE_W-1:0]   sum_r, sum_nxt;

  logic [sbif_pkg::CNT_W-1:0]    cnt_sat;
  logic [sbif_pkg::CNT_W-1:0]    left_new;
  logic [sbif_pkg::BYTE_W-1:0]   hdr_sum;
  logic [sbif_pkg::BYTE_W-1:0]   sum_new;

  always_comb begin
    cnt_sat = ({1'b0, param_count} > MaxP) ? MaxP[sbif_pkg::CNT_W-1:0] : param_count;

    plan.id    = target_id;
    plan.ins   = instruction;
    plan.param = param_byte;
    plan.len   = sbif_pkg::BYTE_W'({1'b0, cnt_sat}) + sbif_pkg::LEN_EXTRA;
    hdr_sum    = target_id + plan.len + instruction;

    if (!in_packet_r) begin
      plan.first     = 1'b1;
      plan.has_param = (cnt_sat != '0);
      sum_new        = plan.has_param ? hdr_sum + param_byte : hdr_sum;
      left_new       = plan.has_param ? cnt_sat - 1'b1 : '0;
    end else begin
      plan.first     = 1'b0;
      plan.has_param = 1'b1;
      sum_new        = sum_r + param_byte;
      left_new       = (left_r != '0) ? left_r - 1'b1 : '0;
    end

    plan.has_chk = (left_new == '0);
    plan.chk     = ~sum_new;

    in_packet_nxt = in_packet_r;
    left_nxt      = left_r;
    sum_nxt       = sum_r;
    if (accept) begin
      if (plan.has_chk) begin
        in_packet_nxt = 1'b0;
        left_nxt      = '0;
        sum_nxt       = '0;
      end else begin
        in_packet_nxt = 1'b1;
        left_nxt      = left_new;
        sum_nxt       = sum_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r <= 1'b0;
      left_r      <= '0;
      sum_r       <= '0;
    end else begin
      in_packet_r <= in_packet_nxt;
      left_r      <= left_nxt;
      sum_r       <= sum_nxt;
    end
  end

endmodule
`default_nettype wire

### rtl/sbif_emitter.sv
// holds one planned item and walks its bytes out, one per cycle while the output register can take a byte
`default_nettype none
module sbif_emitter (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire sbif_pkg::plan_t              plan,
  input  wire logic                         load_ok,
  output logic                              take_ok,
  output logic                              emit,
  output logic [sbif_pkg::BYTE_W-1:0]       emit_byte,
  output logic                              emit_eop
);

  sbif_pkg::slot_t  slot_r, slot_nxt, slot_adv;
  sbif_pkg::plan_t  hold_r, hold_nxt;
  logic             last_slot;

  always_comb begin
    emit      = (slot_r != sbif_pkg::SLOT_IDLE) && load_ok;
    emit_eop  = (slot_r == sbif_pkg::SLOT_CHK);
    last_slot = (slot_r == sbif_pkg::SLOT_CHK) ||
                ((slot_r == sbif_pkg::SLOT_PARAM) && !hold_r.has_chk);
    take_ok   = (slot_r == sbif_pkg::SLOT_IDLE) || (emit && last_slot);

    unique case (slot_r)
      sbif_pkg::SLOT_SYNC0: emit_byte = sbif_pkg::SYNC_BYTE;
      sbif_pkg::SLOT_SYNC1: emit_byte = sbif_pkg::SYNC_BYTE;
      sbif_pkg::SLOT_ID:    emit_byte = hold_r.id;
      sbif_pkg::SLOT_LEN:   emit_byte = hold_r.len;
      sbif_pkg::SLOT_INS:   emit_byte = hold_r.ins;
      sbif_pkg::SLOT_PARAM: emit_byte = hold_r.param;
      sbif_pkg::SLOT_CHK:   emit_byte = hold_r.chk;
      default:              emit_byte = hold_r.chk;
    endcase

    unique case (slot_r)
      sbif_pkg::SLOT_SYNC0: slot_adv = sbif_pkg::SLOT_SYNC1;
      sbif_pkg::SLOT_SYNC1: slot_adv = sbif_pkg::SLOT_ID;
      sbif_pkg::SLOT_ID:    slot_adv = sbif_pkg::SLOT_LEN;
      sbif_pkg::SLOT_LEN:   slot_adv = sbif_pkg::SLOT_INS;
      sbif_pkg::SLOT_INS:   slot_adv = hold_r.has_param ? sbif_pkg::SLOT_PARAM
                                                        : sbif_pkg::SLOT_CHK;
      sbif_pkg::SLOT_PARAM: slot_adv = hold_r.has_chk ? sbif_pkg::SLOT_CHK
                                                      : sbif_pkg::SLOT_IDLE;
      default:              slot_adv = sbif_pkg::SLOT_IDLE;
    endcase

    hold_nxt = hold_r;
    slot_nxt = slot_r;
    if (accept) begin
      hold_nxt = plan;
      slot_nxt = plan.first ? sbif_pkg::SLOT_SYNC0 : sbif_pkg::SLOT_PARAM;
    end else if (emit) begin
      slot_nxt = slot_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= sbif_pkg::SLOT_IDLE;
    end else begin
      slot_r <= slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

endmodule
`default_nettype wire

### rtl/sbif_out_reg.sv
// output register stage of the byte stream
`default_nettype none
module sbif_out_reg (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         load,
  input  wire logic [sbif_pkg::BYTE_W-1:0]  load_byte,
  input  wire logic                         load_eop,
  output logic                              load_ok,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [sbif_pkg::BYTE_W-1:0]       out_tdata,
  output logic                              out_tlast
);

  logic                         valid_r, valid_nxt;
  logic [sbif_pkg::BYTE_W-1:0]  data_r, data_nxt;
  logic                         last_r, last_nxt;

  always_comb begin
    load_ok   = !valid_r || out_tready;
    valid_nxt = valid_r;
    data_nxt  = data_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      data_nxt  = load_byte;
      last_nxt  = load_eop;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    last_r <= last_nxt;
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;

endmodule
`default_nettype wire

### rtl/servo_bus_instruction_framer.sv
// top level of the servo-bus instruction framer
// the first byte an item causes passes the slot sequencer register, then the output register
// throughput: continuing items (one parameter byte) go one transfer per cycle, barring stalls;
//   the last parameter item also sends the checksum and a packet's first item the header,
//   all through the single byte-wide output slot sequencer
// reset: synchronous active-low rst_n clears the packet state, slot sequencer and output valid
`default_nettype none
module servo_bus_instruction_framer #(
  parameter int unsigned MAX_PARAMS = 64  // parameter count limit, 1 to 127
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // input item stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [31:0]  in_tdata,   // target_id[7:0], instruction[15:8],
                                        // param_count[22:16], param_byte[30:23], zero[31]
  // framed byte stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [7:0]        out_tdata,  // tx_byte[7:0]
  output logic              out_tlast   // end_of_packet, set on the checksum byte
);

  // input field unpacking
  logic [sbif_pkg::BYTE_W-1:0] target_id;
  logic [sbif_pkg::BYTE_W-1:0] instruction;
  logic [sbif_pkg::CNT_W-1:0]  param_count;
  logic [sbif_pkg::BYTE_W-1:0] param_byte;

  assign target_id   = in_tdata[7:0];
  assign instruction = in_tdata[15:8];
  assign param_count = in_tdata[22:16];
  assign param_byte  = in_tdata[30:23];

  logic                        accept;     // input transfer this cycle
  logic                        take_ok;    // sequencer free for a new item
  logic                        load_ok;    // output register can take a byte
  logic                        emit;
  logic [sbif_pkg::BYTE_W-1:0] emit_byte;
  logic                        emit_eop;
  sbif_pkg::plan_t             plan;

  assign in_tready = take_ok;
  assign accept    = in_tvalid && take_ok;

  // packet state and byte plan of the incoming item
  sbif_tracker #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .target_id   (target_id),
    .instruction (instruction),
    .param_count (param_count),
    .param_byte  (param_byte),
    .plan        (plan)
  );

  // byte slot sequencer over the held item
  sbif_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .plan      (plan),
    .load_ok   (load_ok),
    .take_ok   (take_ok),
    .emit      (emit),
    .emit_byte (emit_byte),
    .emit_eop  (emit_eop)
  );

  // output register, decouples the sequencer from downstream stalls
  sbif_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (emit),
    .load_byte  (emit_byte),
    .load_eop   (emit_eop),
    .load_ok    (load_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

### rtl/sbif_checker.sv
// port-level checker of the servo-bus instruction framer and its bind
`default_nettype none
module sbif_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [7:0]  out_tdata,
  input wire logic        out_tlast
);

  logic last_xfer;
  assign last_xfer = out_tvalid && out_tready && out_tlast;

  // a stalled byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output byte changed while stalled");

  // nothing leaves straight after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // a packet has at least a header before its checksum
  a_no_back_to_back_end: assert property (@(posedge clk) disable iff (!rst_n)
    last_xfer |=> !last_xfer)
    else $error("two packet ends in consecutive transfers");

  // handshake outputs are always known out of reset
  a_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(out_tvalid) && !$isunknown(in_tready))
    else $error("unknown handshake output");

endmodule

bind servo_bus_instruction_framer sbif_checker u_sbif_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire

### tb/servo_bus_instruction_framer_test.sv
// testbench of the servo-bus instruction framer: directed table, then random packets checked byte by byte
module servo_bus_instruction_framer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PARAMS   = 64;    // must match the block's parameter
  localparam int RANDOM_ITEMS = 140;   // random transfers before the stream is allowed to stop
  localparam int IDLE_LIMIT   = 2000;  // cycles with no transfer on either side before giving up
  localparam int HOLD_AFTER   = 60;    // output bytes taken before the long receiver hold-off
  localparam int HOLD_CYCLES  = 300;   // length of that hold-off
  localparam int DRAIN_CYCLES = 30;    // quiet cycles after the last expected byte
  localparam int MAX_REPORTS  = 10;

  // one wire byte as {end_of_packet, tx_byte}, up to seven per input transfer, in wire order
  typedef logic [0:6][8:0] wire_bytes_t;

  // a directed row: input fields, plus the wire bytes where they are obvious by eye
  typedef struct packed {
    logic [7:0]  id;
    logic [7:0]  ins;
    logic [6:0]  cnt;
    logic [7:0]  pb;
    logic [2:0]  n_typed;  // 0: bytes come from the packet predictor
    wire_bytes_t typed;
  } stim_row_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [31:0] in_tdata  = '0;
  logic       out_tready = 1'b0;
  wire        in_tready;
  wire        out_tvalid;
  wire [7:0]  out_tdata;
  wire        out_tlast;

  // packet predictor state
  logic       pkt_open   = 1'b0;
  logic [6:0] params_due = '0;
  logic [7:0] csum       = '0;

  // wire bytes still owed by the block, oldest first
  logic [8:0] due_bytes[$];

  // idle-pattern state: when a burst flag is set that side runs with no gaps
  logic in_burst  = 1'b0;
  logic out_burst = 1'b0;
  logic draining  = 1'b0;
  logic hold_done = 1'b0;

  int n_items    = 0;
  int n_packets  = 0;
  int n_empty    = 0;
  int n_clipped  = 0;
  int n_bytes    = 0;
  int mismatches = 0;

  servo_bus_instruction_framer #(
    .MAX_PARAMS (MAX_PARAMS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // target_id[7:0], instruction[15:8], param_count[22:16],
                               // param_byte[30:23], zero[31]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // tx_byte[7:0]
    .out_tlast  (out_tlast)    // end_of_packet
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // wire bytes caused by one input transfer; advances the predictor state
  function automatic int frame_item(input logic [7:0] id, input logic [7:0] ins,
                                    input logic [6:0] cnt, input logic [7:0] pb,
                                    output wire_bytes_t bytes);
    int         n;
    logic [6:0] c;
    logic [7:0] len;
    logic       take;
    n     = 0;
    bytes = '0;
    take  = 1'b1;
    if (!pkt_open) begin
      // header: two sync bytes, id, length, instruction; count clipped to the limit
      c   = (int'(cnt) > MAX_PARAMS) ? 7'(MAX_PARAMS) : cnt;
      len = {1'b0, c} + sbif_pkg::LEN_EXTRA;
      bytes[0] = {1'b0, sbif_pkg::SYNC_BYTE};
      bytes[1] = {1'b0, sbif_pkg::SYNC_BYTE};
      bytes[2] = {1'b0, id};
      bytes[3] = {1'b0, len};
      bytes[4] = {1'b0, ins};
      n          = 5;
      csum       = id + len + ins;
      params_due = c;
      pkt_open   = 1'b1;
      take       = (c != 7'd0);  // empty packet: param_byte is not sent
    end
    if (take) begin
      bytes[n] = {1'b0, pb};
      n++;
      csum = csum + pb;
      if (params_due != 7'd0) params_due--;
    end
    if (params_due == 7'd0) begin
      // checksum closes the packet and clears the running sum
      bytes[n] = {1'b1, ~csum};
      n++;
      pkt_open = 1'b0;
      csum     = '0;
    end
    return n;
  endfunction

  // gap before the next transfer on one side, with runs of back-to-back transfers now and then
  function automatic int draw_gap(inout logic burst);
    if ($urandom_range(0, 15) == 0) burst = ~burst;
    return burst ? 0 : int'($urandom_range(0, 19));
  endfunction

  // offer one item, wait for its transfer, then queue the bytes it owes; returns at a falling edge
  task automatic send_item(input logic [7:0] id, input logic [7:0] ins, input logic [6:0] cnt,
                           input logic [7:0] pb, input logic [2:0] n_typed,
                           input wire_bytes_t typed);
    int          gap;
    int          n;
    int          k;
    wire_bytes_t bytes;
    gap = draw_gap(in_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, pb, cnt, ins, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!pkt_open) begin
      n_packets++;
      if (cnt == 7'd0) n_empty++;
      if (int'(cnt) > MAX_PARAMS) n_clipped++;
    end
    n = frame_item(id, ins, cnt, pb, bytes);
    // hand-written rows override the predictor; its state still moves on
    if (n_typed != 3'd0) begin
      bytes = typed;
      n     = int'(n_typed);
    end
    for (k = 0; k < n; k++) due_bytes.push_back(bytes[k]);
    n_items++;
    @(negedge clk);
  endtask

  // receiver: random hold-offs, one long stall, every byte checked against the oldest one due
  initial begin : byte_sink
    int         gap;
    logic [8:0] want;
    logic [8:0] got;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = draining ? 0 : draw_gap(out_burst);
      if (!hold_done && n_bytes >= HOLD_AFTER) begin
        // long stall so the block backs up into its input
        gap       = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      got = {out_tlast, out_tdata};
      if (due_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("byte %0d: tx_byte %02h end_of_packet %0b with nothing due",
                   n_bytes, got[7:0], got[8]);
      end else begin
        want = due_bytes.pop_front();
        if (want[7:0] !== got[7:0] || want[8] !== got[8]) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("byte %0d: expected tx_byte %02h end_of_packet %0b, got %02h %0b",
                     n_bytes, want[7:0], want[8], got[7:0], got[8]);
        end
      end
      n_bytes++;
      @(negedge clk);
    end
  end

  // watchdog: gives up after a long stretch with no transfer anywhere
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle = 0;
      else idle++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    stim_row_t  rows[$];
    stim_row_t  r;
    int         pick;
    int         n_random;
    logic [6:0] cnt;

    // empty packets at both extremes: header and checksum only, param_byte dropped
    rows.push_back('{8'h00, 8'h00, 7'd0, 8'hAB, 3'd6,
                     {9'h0FF, 9'h0FF, 9'h000, 9'h002, 9'h000, 9'h1FD, 9'h000}});
    rows.push_back('{8'hFF, 8'hFF, 7'd0, 8'h00, 3'd6,
                     {9'h0FF, 9'h0FF, 9'h0FF, 9'h002, 9'h0FF, 9'h1FF, 9'h000}});
    // single-parameter packets, all zeros and all ones
    rows.push_back('{8'h00, 8'h00, 7'd1, 8'h00, 3'd7,
                     {9'h0FF, 9'h0FF, 9'h000, 9'h003, 9'h000, 9'h000, 9'h1FC}});
    rows.push_back('{8'hFF, 8'hFF, 7'd1, 8'hFF, 3'd7,
                     {9'h0FF, 9'h0FF, 9'h0FF, 9'h003, 9'h0FF, 9'h0FF, 9'h1FF}});
    // ping-style empty packet
    rows.push_back('{8'h01, 8'h01, 7'd0, 8'h5A, 3'd0, '0});
    // two parameters; header fields on the follow-on transfer must be ignored
    rows.push_back('{8'h01, 8'h03, 7'd2, 8'h1E, 3'd0, '0});
    rows.push_back('{8'hAA, 8'h55, 7'd127, 8'h30, 3'd0, '0});
    // three parameters with byte extremes
    rows.push_back('{8'hFE, 8'h02, 7'd3, 8'h00, 3'd0, '0});
    rows.push_back('{8'h12, 8'h34, 7'd64, 8'hFF, 3'd0, '0});
    rows.push_back('{8'hFF, 8'hFF, 7'd127, 8'h80, 3'd0, '0});
    // four parameters, sync-write style instruction
    rows.push_back('{8'h7F, 8'h83, 7'd4, 8'h01, 3'd0, '0});
    rows.push_back('{8'h00, 8'h00, 7'd0, 8'h02, 3'd0, '0});
    rows.push_back('{8'h00, 8'h00, 7'd0, 8'h04, 3'd0, '0});
    rows.push_back('{8'h00, 8'h00, 7'd0, 8'h08, 3'd0, '0});
    // count far above the limit: clipped packet, finished by the random part
    rows.push_back('{8'h05, 8'h03, 7'd127, 8'h10, 3'd0, '0});
    rows.push_back('{8'h3C, 8'hC3, 7'd1, 8'hA5, 3'd0, '0});
    rows.push_back('{8'hC3, 8'h3C, 7'd2, 8'h5A, 3'd0, '0});
    rows.push_back('{8'h99, 8'h66, 7'd0, 8'hC3, 3'd0, '0});

    // hold reset, then release it
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      r = rows[i];
      send_item(r.id, r.ins, r.cnt, r.pb, r.n_typed, r.typed);
    end

    // sender pause: let every owed byte come out before the random part
    in_tvalid <= 1'b0;
    do @(negedge clk); while (due_bytes.size() != 0);

    // random part: mostly short packets, now and then a long or clipped one;
    // follow-on transfers carry random header fields that must be ignored
    n_random = 0;
    while (n_random < RANDOM_ITEMS || pkt_open) begin
      if (pkt_open) begin
        cnt = 7'($urandom_range(0, 127));
      end else begin
        pick = int'($urandom_range(0, 19));
        if (pick == 0)     cnt = 7'($urandom_range(64, 127));
        else if (pick < 3) cnt = 7'($urandom_range(7, 63));
        else               cnt = 7'($urandom_range(0, 6));
      end
      send_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), cnt,
                8'($urandom_range(0, 255)), 3'd0, '0);
      n_random++;
    end

    // wind down: everything owed must arrive, then nothing more may follow
    in_tvalid <= 1'b0;
    while (due_bytes.size() != 0) @(negedge clk);
    draining = 1'b1;
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("framed %0d packets (%0d empty, %0d with the count clipped) from %0d transfers",
             n_packets, n_empty, n_clipped, n_items);
    $display("%0d wire bytes checked, %0d mismatches", n_bytes, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
